// ===== sv/kct_pkg.sv =====
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants for the k-mer count table
// Table geometry, counter width, item modes and the table access request.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

   localparam int MAX_K       = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int TABLE_BITS  = 2 * MAX_K;
   localparam int RUN_WIDTH   = $clog2(MAX_K + 1);
   localparam int KLEN_WIDTH  = 4;
   localparam int MAXC_WIDTH  = 16;

   typedef logic [TABLE_BITS-1:0]  addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      MODE_SEQ    = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic CSR_KMER_LENGTH = 1'b0;
   localparam logic CSR_MAX_COUNT   = 1'b1;

   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_G       = 8'h47;
   localparam logic [7:0] CH_T       = 8'h54;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // one table access leaving the front stage
   typedef struct packed {
      logic     inc;   // read-modify-write increment
      logic     rd;    // report lookup
      addr_type addr;
   } kct_req_type;

endpackage

`default_nettype wire

// ===== sv/kct_window.sv =====
// ----------------------------------------------------------------------------
// kct_window: base decode and rolling window
// Folds case, codes ACGT, keeps the window and clean-run count (cleared by a record
// item) and forms the table access for each base that completes a k-mer and each lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [1:0]                    mode,
   input  wire logic [7:0]                    char_code,
   input  wire logic [15:0]                   read_index,
   input  wire logic [kct_pkg::KLEN_WIDTH-1:0] kmer_length,
   output      kct_pkg::kct_req_type          req
);
   import kct_pkg::*;

   addr_type               window_ff, window_in;
   logic [RUN_WIDTH-1:0]   run_ff, run_in;
   logic [7:0]             ch_up;
   logic                   is_base;
   logic [1:0]             code;
   logic [RUN_WIDTH-1:0]   k_eff;
   addr_type               k_mask;
   mode_type               mode_e;

   assign mode_e = mode_type'(mode);

   always_comb begin
      ch_up = char_code;
      if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
         ch_up = char_code - CASE_BIT;
      end
      is_base = 1'b1;
      code    = 2'd0;
      case (ch_up)
         CH_A:    code = 2'd0;
         CH_C:    code = 2'd1;
         CH_G:    code = 2'd2;
         CH_T:    code = 2'd3;
         default: is_base = 1'b0;
      endcase
   end

   // zero acts as one, oversized acts as MAX_K
   always_comb begin
      if (kmer_length == '0) begin
         k_eff = RUN_WIDTH'(1);
      end else if (kmer_length > KLEN_WIDTH'(MAX_K)) begin
         k_eff = RUN_WIDTH'(MAX_K);
      end else begin
         k_eff = RUN_WIDTH'(kmer_length);
      end
      for (int i = 0; i < MAX_K; i++) begin
         k_mask[2*i +: 2] = (RUN_WIDTH'(i) < k_eff) ? 2'b11 : 2'b00;
      end
   end

   always_comb begin
      window_in = window_ff;
      run_in    = run_ff;
      req.inc   = 1'b0;
      req.rd    = 1'b0;
      req.addr  = TABLE_BITS'(read_index);
      if (accept) begin
         case (mode_e)
            MODE_SEQ: begin
               if (is_base) begin
                  window_in = {window_ff[TABLE_BITS-3:0], code};
                  if (run_ff < RUN_WIDTH'(MAX_K)) begin
                     run_in = run_ff + RUN_WIDTH'(1);
                  end
                  req.inc  = (run_in >= k_eff);
                  req.addr = window_in & k_mask;
               end else begin
                  run_in = '0;
               end
            end
            MODE_RECORD: begin
               window_in = '0;
               run_in    = '0;
            end
            MODE_READ: req.rd = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff    <= '0;
      end else begin
         window_ff <= window_in;
         run_ff    <= run_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/kct_count_mem.sv =====
// ----------------------------------------------------------------------------
// kct_count_mem: count table storage
// One-read one-write synchronous RAM, registered read, swept to zero
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_count_mem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire kct_pkg::addr_type    rd_addr,
   output      kct_pkg::count_type   rd_data,
   input  wire logic                 wr_en,
   input  wire kct_pkg::addr_type    wr_addr,
   input  wire kct_pkg::count_type   wr_data,
   output      logic                 busy
);
   import kct_pkg::*;

   count_type mem [2**TABLE_BITS];
   count_type rd_data_ff;
   addr_type  clr_addr_ff, clr_addr_in;
   logic      clr_busy_ff, clr_busy_in;

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + TABLE_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // read returns the old entry on a same-edge write
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/kmer_count_table.sv =====
// ----------------------------------------------------------------------------
// kmer_count_table: k-mer occurrence counter with lookup port
// Streams sequence characters into a rolling window, counts each k-base
// word in a 4^MAX_K entry table and answers per-entry lookups.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, set by the table RMW loop, while req_tready is high.
// Lookup path: table read, RMW stage (s1), then the output register, held until rsp_tready.
// Reset: window, run count, configuration and valid flags reset at once; the table
//   is then swept to zero, all 4^MAX_K entries, with req_tready held low.
// Configuration writes are accepted at any time, including the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_count_table (
   input  wire logic         clock,
   input  wire logic         reset,
   // item in
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [23:0]  req_tdata,   // char_code[7:0], read_index[23:8]
   input  wire logic [1:0]   req_tuser,   // mode[1:0]
   // result out
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [23:0]  rsp_tdata,   // entry_count[15:0], entry_seen[16],
                                          // passes_filter[17], zero[23:18]
   // register writes
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import kct_pkg::*;

   // configuration
   logic [KLEN_WIDTH-1:0] kmer_length_ff;
   logic [MAXC_WIDTH-1:0] max_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= KLEN_WIDTH'(8);
         max_count_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KMER_LENGTH: kmer_length_ff <= csr_wdata[KLEN_WIDTH-1:0];
            CSR_MAX_COUNT:   max_count_ff   <= csr_wdata[MAXC_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // front stage
   logic        accept;
   kct_req_type req;

   assign accept = req_tvalid && req_tready;

   kct_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_tuser),
      .char_code   (req_tdata[7:0]),
      .read_index  (req_tdata[23:8]),
      .kmer_length (kmer_length_ff),
      .req         (req)
   );

   // RMW stage: the entry read at the edge that loaded s1 is in hand
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_inc_ff;
   logic      s1_rd_ff;
   addr_type  s1_addr_ff;
   logic      s1_free;
   logic      issue;

   // forwarding: the write made on the same edge as the s1 read
   logic      lw_valid_ff, lw_valid_in;
   addr_type  lw_addr_ff;
   count_type lw_data_ff;

   // memory
   count_type rd_data;
   logic      mem_busy;
   logic      wr_en;
   count_type cur_count;
   count_type new_count;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic        load_rsp;

   logic [31:0] cnt_wide;
   logic [15:0] cnt_out;
   logic        seen;
   logic        pass;

   // a lookup in s1 can only leave when the output register is free
   assign s1_free    = !s1_valid_ff || !s1_rd_ff || !rsp_valid_ff || rsp_tready;
   assign req_tready = !mem_busy && s1_free;
   assign issue      = req.inc || req.rd;

   assign cur_count = (lw_valid_ff && lw_addr_ff == s1_addr_ff) ? lw_data_ff : rd_data;
   assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
   assign wr_en     = s1_valid_ff && s1_inc_ff;

   kct_count_mem u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue),
      .rd_addr (req.addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_count),
      .busy    (mem_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = issue;
      end
      lw_valid_in = lw_valid_ff;
      if (issue) begin
         lw_valid_in = wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         lw_valid_ff <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && issue) begin
         s1_inc_ff  <= req.inc;
         s1_rd_ff   <= req.rd;
         s1_addr_ff <= req.addr;
      end
      if (issue) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= new_count;
      end
   end

   // report fields, clipped to 16 bits for wide counters
   always_comb begin
      cnt_wide = 32'(cur_count);
      cnt_out  = (cnt_wide > 32'hffff) ? 16'hffff : cnt_wide[15:0];
      seen     = (cur_count != '0);
      pass     = seen && (max_count_ff == '0 || cnt_wide <= 32'(max_count_ff));
   end

   assign load_rsp = s1_valid_ff && s1_rd_ff && s1_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {6'd0, pass, seen, cnt_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
